// File: sv/pocm_pkg.sv
// Shared types, codes and result builders for the power output channel manager.
// Used by pocm_pin_unit and power_output_channel_manager; depends on nothing.
`timescale 1ns / 1ps

package pocm_pkg;

   localparam int unsigned PIN_COUNT = 14;

   // Request types.
   localparam logic [1:0] REQ_COMMAND = 2'd0;
   localparam logic [1:0] REQ_STATE   = 2'd1;
   localparam logic [1:0] REQ_FRAME   = 2'd2;

   // Command operations.
   localparam logic [2:0] OP_ON     = 3'd0;
   localparam logic [2:0] OP_OFF    = 3'd1;
   localparam logic [2:0] OP_RESET  = 3'd2;
   localparam logic [2:0] OP_TOGGLE = 3'd3;
   localparam logic [2:0] OP_PWM    = 3'd4;

   // Result kinds.
   localparam logic [1:0] KIND_OUT    = 2'd0;
   localparam logic [1:0] KIND_PWM    = 2'd1;
   localparam logic [1:0] KIND_REPORT = 2'd2;

   // Report modes.
   localparam logic [1:0] MODE_OFF   = 2'd0;
   localparam logic [1:0] MODE_ON    = 2'd1;
   localparam logic [1:0] MODE_PWM   = 2'd2;
   localparam logic [1:0] MODE_FAULT = 2'd3;

   // Output command frame values.
   localparam logic [1:0] FVAL_OFF   = 2'd0;
   localparam logic [1:0] FVAL_ON    = 2'd1;
   localparam logic [1:0] FVAL_CLEAR = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_DEVICE_ADDRESS  = 2'd0;
   localparam logic [1:0] CSR_PDM_NUMBER      = 2'd1;
   localparam logic [1:0] CSR_ADDRESS_CLAIMED = 2'd2;

   localparam logic [3:0]  PWM_PIN_A   = 4'd12;
   localparam logic [3:0]  PWM_PIN_B   = 4'd13;
   localparam logic [3:0]  LAST_PIN    = 4'd13;
   localparam logic [7:0]  MAX_PIN     = 8'd13;
   localparam logic [7:0]  MAX_PIN_NUM = 8'd14;
   localparam logic [17:0] FAULT_PGN   = 18'h0EF00;
   localparam logic [7:0]  FAULT_BYTE0 = 8'h04;
   localparam logic [7:0]  FAULT_BYTE1 = 8'h1B;
   localparam logic [7:0]  FAULT_BYTE2 = 8'h01;
   localparam logic [7:0]  DUTY_FULL   = 8'hFF;
   localparam logic [7:0]  DUTY_ZERO   = 8'h00;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [3:0] frame_pin;
      logic [1:0] frame_value;
      logic [7:0] pwm_duty_a;
      logic [7:0] pwm_duty_b;
      logic [3:0] report_pin;
      logic [1:0] report_mode;
      logic [7:0] report_duty;
      logic       last;
   } rsp_type;

   // What the shared pin unit tells about one pin.
   typedef struct packed {
      logic       on;
      logic       fault;
      logic       pwm;
      logic [1:0] mode;
      logic [7:0] duty;
   } pin_info_type;

   function automatic rsp_type out_frame(logic [3:0] pin, logic [1:0] value);
      rsp_type r;
      r = '0;
      r.out_kind    = KIND_OUT;
      r.frame_pin   = pin + 4'd1;
      r.frame_value = value;
      return r;
   endfunction

   function automatic rsp_type pwm_frame(logic [7:0] duty_a, logic [7:0] duty_b);
      rsp_type r;
      r = '0;
      r.out_kind   = KIND_PWM;
      r.pwm_duty_a = duty_a;
      r.pwm_duty_b = duty_b;
      return r;
   endfunction

   function automatic rsp_type report(logic [3:0] pin, logic [1:0] mode, logic [7:0] duty);
      rsp_type r;
      r = '0;
      r.out_kind    = KIND_REPORT;
      r.report_pin  = pin;
      r.report_mode = mode;
      r.report_duty = duty;
      return r;
   endfunction

endpackage

// File: sv/pocm_pin_unit.sv
// Shared pin lookup: selects one pin's on and fault bits and forms its state report.
// Depends on pocm_pkg.
`timescale 1ns / 1ps

module pocm_pin_unit (
   input  logic [3:0]             pin,
   input  logic [13:0]            on_bits,
   input  logic [13:0]            fault_bits,
   input  logic [7:0]             duty_a,
   input  logic [7:0]             duty_b,
   output pocm_pkg::pin_info_type info
);

   logic [13:0] on_sh;
   logic [13:0] fault_sh;

   assign on_sh    = on_bits >> pin;
   assign fault_sh = fault_bits >> pin;

   always_comb begin
      info       = '0;
      info.on    = on_sh[0];
      info.fault = fault_sh[0];
      info.pwm   = (pin == pocm_pkg::PWM_PIN_A) || (pin == pocm_pkg::PWM_PIN_B);
      info.duty  = pocm_pkg::DUTY_FULL;
      if (fault_sh[0]) begin
         info.mode = pocm_pkg::MODE_FAULT;
      end else if (pin == pocm_pkg::PWM_PIN_A) begin
         info.mode = pocm_pkg::MODE_PWM;
         info.duty = duty_a;
      end else if (pin == pocm_pkg::PWM_PIN_B) begin
         info.mode = pocm_pkg::MODE_PWM;
         info.duty = duty_b;
      end else begin
         info.mode = on_sh[0] ? pocm_pkg::MODE_ON : pocm_pkg::MODE_OFF;
      end
   end

endmodule

// File: sv/power_output_channel_manager.sv
// Power output channel manager: top level with sequencer, pin state and result register.
// Depends on pocm_pkg and pocm_pin_unit.
//
// Usage: an item enters on the req_ channel (req_valid high, req_stall low) and is one
// of a power command, a state request or a received fault frame. Results leave on the
// rsp_ channel one at a time; rsp_last marks the final result of an item. Items that
// are ignored produce no result. Configuration (device address, module number,
// address-claimed flag) is written on the csr_ channel, which is always ready.
// Order of work: the item is latched on acceptance and decoded in ST_EXEC, which loads
// any first result into the output register. A state request gives none there; its
// reports follow from ST_SCAN, which walks the fourteen pins through the shared pin unit,
// one report per cycle unless the receiver stalls. A command passes through ST_EXEC,
// and through ST_SECOND as well if it emits a frame plus a report; a fault frame emits at
// most one report. The sequencer and that single pin unit set this order; req_stall is
// high from acceptance until the last result is loaded into the output register.
// When the receiver stalls, the output register holds its result and the sequencer
// waits; the next item can be accepted while the final result still waits.
// Reset clears all pin state, duties and configuration to zero and empties the output.
`timescale 1ns / 1ps

module power_output_channel_manager (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_cmd_pdm,
   input  logic [7:0]  req_cmd_pin,
   input  logic [2:0]  req_cmd_op,
   input  logic [7:0]  req_cmd_duty,
   input  logic [7:0]  req_frame_source,
   input  logic [17:0] req_frame_pgn,
   input  logic [7:0]  req_frame_byte0,
   input  logic [7:0]  req_frame_byte1,
   input  logic [7:0]  req_frame_byte2,
   input  logic [7:0]  req_frame_pin_number,
   input  logic [7:0]  req_frame_fault,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_out_kind,
   output logic [3:0]  rsp_frame_pin,
   output logic [1:0]  rsp_frame_value,
   output logic [7:0]  rsp_pwm_duty_a,
   output logic [7:0]  rsp_pwm_duty_b,
   output logic [3:0]  rsp_report_pin,
   output logic [1:0]  rsp_report_mode,
   output logic [7:0]  rsp_report_duty,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EXEC   = 4'b0010,
      ST_SECOND = 4'b0100,
      ST_SCAN   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Configuration.
   logic [7:0] dev_addr_ff;
   logic [7:0] pdm_num_ff;
   logic       claimed_ff;

   // Pin state.
   logic [13:0] on_bits_ff, on_bits_in;
   logic [13:0] fault_bits_ff, fault_bits_in;
   logic [7:0]  duty_a_ff, duty_a_in;
   logic [7:0]  duty_b_ff, duty_b_in;
   logic [7:0]  fduty_a_ff, fduty_a_in;
   logic [7:0]  fduty_b_ff, fduty_b_in;

   // Latched item.
   logic [1:0] type_ff;
   logic       ok_ff;
   logic [3:0] pin_ff;
   logic [2:0] op_ff;
   logic [7:0] duty_ff;
   logic       fault_val_ff;

   logic [3:0] cnt_ff, cnt_in;

   // Output register and second result waiting behind it.
   logic                  rsp_valid_ff, rsp_valid_in;
   pocm_pkg::rsp_type     rsp_ff, rsp_in;
   pocm_pkg::rsp_type     pend_ff, pend_in;

   logic req_fire;
   logic slot_free;
   logic cmd_ok;
   logic frame_ok;
   logic ok_in;
   logic [7:0] pnum_m1;
   logic [3:0] pin_in;

   logic [3:0]             unit_pin;
   pocm_pkg::pin_info_type info;

   // Execution results.
   logic [1:0]        n_res;
   pocm_pkg::rsp_type res1;
   pocm_pkg::rsp_type res2;
   logic              do_duty;
   logic [7:0]        new_duty;
   logic              do_switch;
   logic              sw_val;
   logic [7:0]        cur_duty;
   logic [7:0]        cur_fduty;
   logic [13:0]       pin_mask;

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign pnum_m1  = req_frame_pin_number - 8'd1;
   assign cmd_ok   = claimed_ff && (req_cmd_pdm == pdm_num_ff) &&
                     (req_cmd_pin <= pocm_pkg::MAX_PIN);
   assign frame_ok = claimed_ff && (req_frame_source == dev_addr_ff) &&
                     (req_frame_pgn == pocm_pkg::FAULT_PGN) &&
                     (req_frame_byte0 == pocm_pkg::FAULT_BYTE0) &&
                     (req_frame_byte1 == pocm_pkg::FAULT_BYTE1) &&
                     (req_frame_byte2 == pocm_pkg::FAULT_BYTE2) &&
                     (req_frame_pin_number != 8'd0) &&
                     (req_frame_pin_number <= pocm_pkg::MAX_PIN_NUM);

   always_comb begin
      unique case (req_type)
         pocm_pkg::REQ_COMMAND: ok_in = cmd_ok;
         pocm_pkg::REQ_STATE:   ok_in = 1'b1;
         pocm_pkg::REQ_FRAME:   ok_in = frame_ok;
         default:               ok_in = 1'b0;
      endcase
   end

   assign pin_in = (req_type == pocm_pkg::REQ_FRAME) ? pnum_m1[3:0] : req_cmd_pin[3:0];

   assign unit_pin = (state_ff == ST_SCAN) ? cnt_ff : pin_ff;

   pocm_pin_unit u_pin (
      .pin        (unit_pin),
      .on_bits    (on_bits_ff),
      .fault_bits (fault_bits_ff),
      .duty_a     (duty_a_ff),
      .duty_b     (duty_b_ff),
      .info       (info)
   );

   assign pin_mask  = 14'd1 << pin_ff;
   assign cur_duty  = (pin_ff == pocm_pkg::PWM_PIN_A) ? duty_a_ff : duty_b_ff;
   assign cur_fduty = (pin_ff == pocm_pkg::PWM_PIN_A) ? fduty_a_ff : fduty_b_ff;

   // Decode the latched item into state updates and up to two results.
   always_comb begin
      on_bits_in    = on_bits_ff;
      fault_bits_in = fault_bits_ff;
      duty_a_in     = duty_a_ff;
      duty_b_in     = duty_b_ff;
      fduty_a_in    = fduty_a_ff;
      fduty_b_in    = fduty_b_ff;
      n_res         = 2'd0;
      res1          = '0;
      res2          = '0;
      do_duty       = 1'b0;
      new_duty      = pocm_pkg::DUTY_ZERO;
      do_switch     = 1'b0;
      sw_val        = 1'b0;

      if (ok_ff && type_ff == pocm_pkg::REQ_COMMAND) begin
         case (op_ff)
            pocm_pkg::OP_ON: begin
               do_duty   = info.pwm;
               new_duty  = pocm_pkg::DUTY_FULL;
               do_switch = !info.pwm;
               sw_val    = 1'b1;
            end
            pocm_pkg::OP_OFF: begin
               do_duty   = info.pwm;
               new_duty  = pocm_pkg::DUTY_ZERO;
               do_switch = !info.pwm;
               sw_val    = 1'b0;
            end
            pocm_pkg::OP_TOGGLE: begin
               do_duty   = info.pwm;
               new_duty  = (cur_fduty == pocm_pkg::DUTY_ZERO) ? pocm_pkg::DUTY_FULL
                                                              : pocm_pkg::DUTY_ZERO;
               do_switch = !info.pwm;
               sw_val    = !info.on;
            end
            pocm_pkg::OP_PWM: begin
               do_duty  = info.pwm;
               new_duty = duty_ff;
            end
            pocm_pkg::OP_RESET: begin
               if (info.fault) begin
                  fault_bits_in = fault_bits_ff & ~pin_mask;
                  n_res = 2'd2;
                  res1  = pocm_pkg::out_frame(pin_ff, pocm_pkg::FVAL_CLEAR);
                  res2  = pocm_pkg::report(pin_ff, pocm_pkg::MODE_OFF, pocm_pkg::DUTY_FULL);
               end
            end
            default: begin
            end
         endcase

         if (do_duty) begin
            // The duty and frame byte are rewritten even when nothing changes.
            if (pin_ff == pocm_pkg::PWM_PIN_A) begin
               duty_a_in  = new_duty;
               fduty_a_in = new_duty;
            end else begin
               duty_b_in  = new_duty;
               fduty_b_in = new_duty;
            end
            if (new_duty != cur_duty) begin
               n_res = 2'd2;
               res1  = pocm_pkg::pwm_frame(fduty_a_in, fduty_b_in);
               res2  = pocm_pkg::report(pin_ff, pocm_pkg::MODE_PWM, new_duty);
            end
         end

         if (do_switch && (info.on != sw_val) && !info.fault) begin
            on_bits_in = sw_val ? (on_bits_ff | pin_mask) : (on_bits_ff & ~pin_mask);
            n_res = 2'd2;
            res1  = pocm_pkg::out_frame(pin_ff, sw_val ? pocm_pkg::FVAL_ON
                                                       : pocm_pkg::FVAL_OFF);
            res2  = pocm_pkg::report(pin_ff, sw_val ? pocm_pkg::MODE_ON : pocm_pkg::MODE_OFF,
                                     pocm_pkg::DUTY_FULL);
         end
      end else if (ok_ff && type_ff == pocm_pkg::REQ_FRAME) begin
         if (info.fault != fault_val_ff) begin
            if (fault_val_ff) begin
               fault_bits_in = fault_bits_ff | pin_mask;
               if (pin_ff == pocm_pkg::PWM_PIN_A) begin
                  fduty_a_in = pocm_pkg::DUTY_ZERO;
               end else if (pin_ff == pocm_pkg::PWM_PIN_B) begin
                  fduty_b_in = pocm_pkg::DUTY_ZERO;
               end
            end else begin
               fault_bits_in = fault_bits_ff & ~pin_mask;
            end
            n_res = 2'd1;
            res1  = pocm_pkg::report(pin_ff, fault_val_ff ? pocm_pkg::MODE_FAULT
                                                          : pocm_pkg::MODE_OFF,
                                     pocm_pkg::DUTY_FULL);
         end
      end

      res1.last = (n_res == 2'd1);
      res2.last = 1'b1;
   end

   // Sequencer and output register.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               if (n_res != 2'd0) begin
                  rsp_in       = res1;
                  rsp_valid_in = 1'b1;
               end
               pend_in = res2;
               cnt_in  = 4'd0;
               if (ok_ff && type_ff == pocm_pkg::REQ_STATE) begin
                  state_in = ST_SCAN;
               end else if (n_res == 2'd2) begin
                  state_in = ST_SECOND;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SECOND: begin
            if (slot_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (slot_free) begin
               rsp_in       = pocm_pkg::report(cnt_ff, info.mode, info.duty);
               rsp_in.last  = (cnt_ff == pocm_pkg::LAST_PIN);
               rsp_valid_in = 1'b1;
               cnt_in       = cnt_ff + 4'd1;
               if (cnt_ff == pocm_pkg::LAST_PIN) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= 4'd0;
         dev_addr_ff   <= 8'd0;
         pdm_num_ff    <= 8'd0;
         claimed_ff    <= 1'b0;
         on_bits_ff    <= '0;
         fault_bits_ff <= '0;
         duty_a_ff     <= '0;
         duty_b_ff     <= '0;
         fduty_a_ff    <= '0;
         fduty_b_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               pocm_pkg::CSR_DEVICE_ADDRESS:  dev_addr_ff <= csr_data;
               pocm_pkg::CSR_PDM_NUMBER:      pdm_num_ff  <= csr_data;
               pocm_pkg::CSR_ADDRESS_CLAIMED: claimed_ff  <= csr_data[0];
               default: begin
               end
            endcase
         end
         if (state_ff == ST_EXEC && slot_free) begin
            on_bits_ff    <= on_bits_in;
            fault_bits_ff <= fault_bits_in;
            duty_a_ff     <= duty_a_in;
            duty_b_ff     <= duty_b_in;
            fduty_a_ff    <= fduty_a_in;
            fduty_b_ff    <= fduty_b_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
      if (req_fire) begin
         type_ff      <= req_type;
         ok_ff        <= ok_in;
         pin_ff       <= pin_in;
         op_ff        <= req_cmd_op;
         duty_ff      <= req_cmd_duty;
         fault_val_ff <= (req_frame_fault != 8'd0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_kind    = rsp_ff.out_kind;
   assign rsp_frame_pin   = rsp_ff.frame_pin;
   assign rsp_frame_value = rsp_ff.frame_value;
   assign rsp_pwm_duty_a  = rsp_ff.pwm_duty_a;
   assign rsp_pwm_duty_b  = rsp_ff.pwm_duty_b;
   assign rsp_report_pin  = rsp_ff.report_pin;
   assign rsp_report_mode = rsp_ff.report_mode;
   assign rsp_report_duty = rsp_ff.report_duty;
   assign rsp_last        = rsp_ff.last;

endmodule
